FILE: src/recursive_lock_with_wait_queue_core_macros.svh
// Assertion helpers for the checker file of the lock core.
`ifndef RECURSIVE_LOCK_WITH_WAIT_QUEUE_CORE_MACROS_SVH
`define RECURSIVE_LOCK_WITH_WAIT_QUEUE_CORE_MACROS_SVH

// Check a property only while out of reset.
`define RLWQ_ASSERT_ON(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property at every edge, reset cycles included.
`define RLWQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/rlwq_pkg.sv
`timescale 1ns / 1ps

package rlwq_pkg;

    localparam int MAX_THREADS  = 16;
    localparam int COUNT_BITS   = 8;
    localparam int TID_W        = $clog2(MAX_THREADS);
    localparam int FILL_W       = $clog2(MAX_THREADS + 1);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IN_TDATA_W   = ((TID_W + 7) / 8) * 8;
    localparam int RESULT_W     = 3 + 1 + TID_W + 1 + TID_W + COUNT_BITS;
    localparam int OUT_TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    typedef logic [TID_W-1:0]      tid_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [FILL_W-1:0]     fill_t;

    typedef enum logic {
        CMD_ACQUIRE = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_GRANTED         = 3'd0,
        ST_NESTED          = 3'd1,
        ST_QUEUED          = 3'd2,
        ST_REL_NESTED      = 3'd3,
        ST_RELEASED        = 3'd4,
        ST_NOT_HOLDER      = 3'd5,
        ST_ALREADY_WAITING = 3'd6,
        ST_COUNT_OVERFLOW  = 3'd7
    } status_t;

    typedef struct packed {
        cmd_t cmd;
        tid_t tid;
    } req_t;

    // Lowest field last, so the packed image matches the tdata layout.
    typedef struct packed {
        count_t  hold_depth;
        tid_t    holder_thread;
        logic    holder_valid;
        tid_t    woken_thread;
        logic    woken_valid;
        status_t status;
    } result_t;

    localparam count_t DEPTH_MAX = '1;
    localparam fill_t  FILL_FULL = fill_t'(MAX_THREADS);

    // Slot bit positions inside the output tdata.
    localparam int OUT_STATUS_LSB   = 0;
    localparam int OUT_WVALID_BIT   = 3;
    localparam int OUT_WTHREAD_LSB  = 4;
    localparam int OUT_HVALID_BIT   = OUT_WTHREAD_LSB + TID_W;
    localparam int OUT_HTHREAD_LSB  = OUT_HVALID_BIT + 1;
    localparam int OUT_DEPTH_LSB    = OUT_HTHREAD_LSB + TID_W;

    function automatic tid_t next_slot(input tid_t slot);
        return (slot == tid_t'(MAX_THREADS - 1)) ? '0 : slot + tid_t'(1);
    endfunction

endpackage

FILE: src/rlwq_front.sv
`timescale 1ns / 1ps

module rlwq_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rlwq_pkg::IN_TDATA_W-1:0]   s_tdata,   // [3:0] thread_id, rest zero
    input  logic                              s_tuser,   // [0] command
    output logic                              req_valid,
    input  logic                              req_ready,
    output rlwq_pkg::req_t                    req
);

    logic           valid_reg, valid_next;
    rlwq_pkg::req_t req_reg, req_next;
    logic           accept;

    // Take a new transaction when none is held or the held one leaves this cycle.
    assign s_tready  = !valid_reg || req_ready;
    assign accept    = s_tvalid && s_tready;
    assign req_valid = valid_reg;
    assign req       = req_reg;

    always_comb begin
        req_next     = req_reg;
        req_next.cmd = rlwq_pkg::cmd_t'(s_tuser);
        req_next.tid = s_tdata[rlwq_pkg::TID_W-1:0];
        if (accept) begin
            valid_next = 1'b1;
        end else if (req_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= req_next;
        end
    end

endmodule

FILE: src/rlwq_queue.sv
`timescale 1ns / 1ps

module rlwq_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  rlwq_pkg::req_t in_req,
    output logic           out_valid,
    input  logic           out_ready,
    output rlwq_pkg::req_t out_req
);

    rlwq_pkg::req_t                    entry_reg [rlwq_pkg::QUEUE_DEPTH];
    logic [rlwq_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [rlwq_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [rlwq_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                              push, pop;

    assign in_ready  = count_reg != rlwq_pkg::QCNT_W'(rlwq_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_req   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + rlwq_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + rlwq_pkg::QPTR_W'(1) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + rlwq_pkg::QCNT_W'(1);
            2'b01:   count_next = count_reg - rlwq_pkg::QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

FILE: src/rlwq_back.sv
`timescale 1ns / 1ps

module rlwq_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  rlwq_pkg::req_t                    in_req,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rlwq_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    // Lock state
    logic                              held_reg, held_next;
    rlwq_pkg::tid_t                    owner_reg, owner_next;
    rlwq_pkg::count_t                  depth_reg, depth_next;
    // Waiter ring
    rlwq_pkg::tid_t                    wait_mem [rlwq_pkg::MAX_THREADS];
    rlwq_pkg::tid_t                    head_reg, head_next;
    rlwq_pkg::tid_t                    tail_reg, tail_next;
    rlwq_pkg::fill_t                   fill_reg, fill_next;
    logic [rlwq_pkg::MAX_THREADS-1:0]  mask_reg, mask_next;
    // Result register
    logic                              out_valid_reg, out_valid_next;
    rlwq_pkg::result_t                 out_reg, out_next;

    logic                              fire;
    logic                              own;
    logic                              do_push;
    rlwq_pkg::tid_t                    head_tid;
    logic [rlwq_pkg::RESULT_W-1:0]     out_flat;

    assign in_ready = !out_valid_reg || m_tready;
    assign fire     = in_valid && in_ready;
    assign own      = held_reg && (owner_reg == in_req.tid);
    assign head_tid = wait_mem[head_reg];
    assign out_flat = out_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rlwq_pkg::OUT_TDATA_W'(out_flat);

    always_comb begin
        held_next  = held_reg;
        owner_next = owner_reg;
        depth_next = depth_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        fill_next  = fill_reg;
        mask_next  = mask_reg;
        do_push    = 1'b0;
        out_next   = out_reg;
        out_next.woken_valid  = 1'b0;
        out_next.woken_thread = '0;

        unique case (in_req.cmd)
            rlwq_pkg::CMD_ACQUIRE: begin
                priority if (own) begin
                    if (depth_reg == rlwq_pkg::DEPTH_MAX) begin
                        out_next.status = rlwq_pkg::ST_COUNT_OVERFLOW;
                    end else begin
                        depth_next      = depth_reg + rlwq_pkg::count_t'(1);
                        out_next.status = rlwq_pkg::ST_NESTED;
                    end
                end else if (mask_reg[in_req.tid]) begin
                    out_next.status = rlwq_pkg::ST_ALREADY_WAITING;
                end else if (!held_reg) begin
                    held_next       = 1'b1;
                    owner_next      = in_req.tid;
                    depth_next      = rlwq_pkg::count_t'(1);
                    out_next.status = rlwq_pkg::ST_GRANTED;
                end else if (fill_reg == rlwq_pkg::FILL_FULL) begin
                    out_next.status = rlwq_pkg::ST_ALREADY_WAITING;
                end else begin
                    do_push                = 1'b1;
                    tail_next              = rlwq_pkg::next_slot(tail_reg);
                    fill_next              = fill_reg + rlwq_pkg::fill_t'(1);
                    mask_next[in_req.tid]  = 1'b1;
                    out_next.status        = rlwq_pkg::ST_QUEUED;
                end
            end
            rlwq_pkg::CMD_RELEASE: begin
                priority if (!own) begin
                    out_next.status = rlwq_pkg::ST_NOT_HOLDER;
                end else if (depth_reg > rlwq_pkg::count_t'(1)) begin
                    depth_next      = depth_reg - rlwq_pkg::count_t'(1);
                    out_next.status = rlwq_pkg::ST_REL_NESTED;
                end else begin
                    held_next       = 1'b0;
                    owner_next      = '0;
                    depth_next      = '0;
                    out_next.status = rlwq_pkg::ST_RELEASED;
                    if (fill_reg != '0) begin
                        head_next             = rlwq_pkg::next_slot(head_reg);
                        fill_next             = fill_reg - rlwq_pkg::fill_t'(1);
                        mask_next[head_tid]   = 1'b0;
                        out_next.woken_valid  = 1'b1;
                        out_next.woken_thread = head_tid;
                    end
                end
            end
            default: begin
                out_next.status = rlwq_pkg::ST_NOT_HOLDER;
            end
        endcase

        out_next.holder_valid  = held_next;
        out_next.holder_thread = owner_next;
        out_next.hold_depth    = depth_next;

        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg      <= 1'b0;
            owner_reg     <= '0;
            depth_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (fire) begin
                held_reg  <= held_next;
                owner_reg <= owner_next;
                depth_reg <= depth_next;
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                fill_reg  <= fill_next;
                mask_reg  <= mask_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= out_next;
        end
        if (fire && do_push) begin
            wait_mem[tail_reg] <= in_req.tid;
        end
    end

endmodule

FILE: src/recursive_lock_with_wait_queue_core.sv
`timescale 1ns / 1ps

// Recursive lock with a FIFO of waiting threads.
// Request channel (s_): one transaction is an acquire or a release; s_tuser
// carries the command (0 acquire, 1 release), s_tdata the thread id.
// Result channel (m_): exactly one transaction per request, in request order,
// carrying status, the woken waiter (if any) and the holder after the step.
// Path: front register, two-entry request queue, lock engine and result
// register. Throughput: one request per cycle unless the receiver stalls;
// the lock engine updates all state, waiter ring and waiting mask in the
// single cycle it fires.
// Reset (aresetn low, synchronous): the lock is free, the waiter ring and
// mask are empty, and both channels drop their valid flags.
// Receiver stall: the result register holds its transaction; the engine
// stops, the queue fills, and s_tready falls once the front register is
// also occupied. No transaction is lost or repeated.
module recursive_lock_with_wait_queue_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rlwq_pkg::IN_TDATA_W-1:0]   s_tdata,   // [3:0] thread_id, [7:4] zero
    input  logic                              s_tuser,   // [0] command
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [2:0] status, [3] woken_valid, [7:4] woken_thread, [8] holder_valid,
    // [12:9] holder_thread, [20:13] hold_depth, [23:21] zero
    output logic [rlwq_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    // Front register to queue
    logic           fq_valid, fq_ready;
    rlwq_pkg::req_t fq_req;
    // Queue to lock engine
    logic           qb_valid, qb_ready;
    rlwq_pkg::req_t qb_req;

    // Accept and capture requests.
    rlwq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .req_valid (fq_valid),
        .req_ready (fq_ready),
        .req       (fq_req)
    );

    // Decouple intake from the lock engine so either side can stall.
    rlwq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_req    (fq_req),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_req   (qb_req)
    );

    // Carry out the request against the lock state and register the result.
    rlwq_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (qb_valid),
        .in_ready  (qb_ready),
        .in_req    (qb_req),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: src/rlwq_checker.sv
`timescale 1ns / 1ps
`include "recursive_lock_with_wait_queue_core_macros.svh"

module rlwq_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [rlwq_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    logic                      wvalid;
    logic                      hvalid;
    logic [2:0]                status;
    rlwq_pkg::tid_t            hthread;
    rlwq_pkg::count_t          depth;

    assign status  = m_tdata[rlwq_pkg::OUT_STATUS_LSB +: 3];
    assign wvalid  = m_tdata[rlwq_pkg::OUT_WVALID_BIT];
    assign hvalid  = m_tdata[rlwq_pkg::OUT_HVALID_BIT];
    assign hthread = m_tdata[rlwq_pkg::OUT_HTHREAD_LSB +: rlwq_pkg::TID_W];
    assign depth   = m_tdata[rlwq_pkg::OUT_DEPTH_LSB +: rlwq_pkg::COUNT_BITS];

    // No result may be offered in the cycle after a reset edge.
    `RLWQ_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "m_tvalid after reset")

    // A stalled result transaction stays put.
    `RLWQ_ASSERT_ON(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed under stall")

    // A held lock always has a nonzero depth, a free lock reports no holder.
    `RLWQ_ASSERT_ON(a_holder_depth, aclk, aresetn, m_tvalid |-> (hvalid == (depth != '0)) && (hvalid || hthread == '0), "holder and depth disagree")

    // A waiter is woken only by the final release, which leaves the lock free.
    `RLWQ_ASSERT_ON(a_wake_on_release, aclk, aresetn, m_tvalid && wvalid |-> status == rlwq_pkg::ST_RELEASED && !hvalid, "wake without final release")

endmodule

bind recursive_lock_with_wait_queue_core rlwq_checker u_rlwq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import rlwq_pkg::*;

    // Quiet cycles (no transaction on either channel) before the run is declared hung.
    localparam int QUIET_LIMIT  = 2000;
    // Cycles the receiver holds m_tready low to back the block up into its input.
    localparam int BACKUP_CYCLES = 64;
    localparam int PHASE_ITEMS  = 410;
    // Margin left after the last result before the run ends.
    localparam int DRAIN_CYCLES = 12;

    // Shadow of the lock: holder, recursion depth, waiter ring and waiting flags.
    typedef struct packed {
        logic                    held;
        tid_t                    owner;
        count_t                  depth;
        tid_t [MAX_THREADS-1:0]  ring;
        tid_t                    head;
        tid_t                    tail;
        fill_t                   fill;
        logic [MAX_THREADS-1:0]  waiting;
    } lock_state_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // [3:0] thread_id, upper bits zero
    logic                   s_tuser  = 1'b0; // [0] command
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [2:0] status, [3] woken_valid, [7:4] woken_thread, [8] holder_valid,
    // [12:9] holder_thread, [20:13] hold_depth, upper bits zero
    logic [OUT_TDATA_W-1:0] m_tdata;

    req_t        request_q[$];   // requests waiting to be offered
    result_t     lock_result_q[$]; // predicted results, oldest first
    lock_state_t gen_lock;       // lock as the stimulus generator sees it
    lock_state_t live_lock;      // lock as predicted from accepted requests
    logic        rewake_due = 1'b0;
    tid_t        rewake_tid = '0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int backup_reqs = 0;
    int backup_done = 0;
    int backup_left = 0;
    int quiet_cycles = 0;
    int mismatch_cnt = 0;
    int result_idx = 0;

    recursive_lock_with_wait_queue_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic tid_t ring_advance(input tid_t slot);
        return (int'(slot) == MAX_THREADS - 1) ? '0 : slot + tid_t'(1);
    endfunction

    // Apply one request to a lock shadow and return the result it must produce.
    // Thread ids cannot exceed the thread count at this width, so no range check.
    function automatic result_t lock_step(inout lock_state_t s, input cmd_t cmd,
                                          input tid_t tid);
        result_t r;
        tid_t    w;
        r = '0;
        if (cmd == CMD_ACQUIRE) begin
            if (s.held && s.owner == tid) begin
                // nest one level deeper unless the depth counter is saturated
                if (s.depth == DEPTH_MAX) begin
                    r.status = ST_COUNT_OVERFLOW;
                end else begin
                    s.depth  = s.depth + count_t'(1);
                    r.status = ST_NESTED;
                end
            end else if (s.waiting[tid]) begin
                // a queued thread stays queued, even if the lock is free now
                r.status = ST_ALREADY_WAITING;
            end else if (!s.held) begin
                s.held   = 1'b1;
                s.owner  = tid;
                s.depth  = count_t'(1);
                r.status = ST_GRANTED;
            end else if (s.fill >= FILL_FULL) begin
                r.status = ST_ALREADY_WAITING;
            end else begin
                s.ring[s.tail]   = tid;
                s.tail           = ring_advance(s.tail);
                s.fill           = s.fill + fill_t'(1);
                s.waiting[tid]   = 1'b1;
                r.status         = ST_QUEUED;
            end
        end else begin
            if (!s.held || s.owner != tid) begin
                r.status = ST_NOT_HOLDER;
            end else if (s.depth > count_t'(1)) begin
                s.depth  = s.depth - count_t'(1);
                r.status = ST_REL_NESTED;
            end else begin
                // final release: free the lock and wake the head waiter
                s.held  = 1'b0;
                s.owner = '0;
                s.depth = '0;
                if (s.fill != '0) begin
                    w              = s.ring[s.head];
                    s.head         = ring_advance(s.head);
                    s.fill         = s.fill - fill_t'(1);
                    s.waiting[w]   = 1'b0;
                    r.woken_valid  = 1'b1;
                    r.woken_thread = w;
                end
                r.status = ST_RELEASED;
            end
        end
        r.holder_valid  = s.held;
        r.holder_thread = s.held ? s.owner : '0;
        r.hold_depth    = s.held ? s.depth : '0;
        return r;
    endfunction

    // Queue one request and advance the generator's view of the lock.
    task automatic push_request(input cmd_t cmd, input tid_t tid);
        result_t r;
        req_t    q;
        r = lock_step(gen_lock, cmd, tid);
        if (r.woken_valid) begin
            rewake_due = 1'b1;
            rewake_tid = r.woken_thread;
        end else if (cmd == CMD_ACQUIRE && tid == rewake_tid) begin
            rewake_due = 1'b0;
        end
        q.cmd = cmd;
        q.tid = tid;
        request_q.push_back(q);
    endtask

    // Mostly plausible lock traffic: woken threads retry, the holder nests and
    // unwinds, other threads pile up in the waiter ring; the rest is noise.
    task automatic push_traffic(input int n);
        int roll;
        int pick;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            pick = $urandom_range(0, 99);
            if (roll < 15) begin
                push_request(cmd_t'($urandom_range(0, 1)), tid_t'($urandom_range(0, 15)));
            end else if (!gen_lock.held) begin
                if (rewake_due && pick < 70)
                    push_request(CMD_ACQUIRE, rewake_tid);
                else
                    push_request(CMD_ACQUIRE, tid_t'($urandom_range(0, 15)));
            end else if (pick < 25 && gen_lock.depth < count_t'(6)) begin
                push_request(CMD_ACQUIRE, gen_lock.owner);
            end else if (pick < 55) begin
                push_request(CMD_RELEASE, gen_lock.owner);
            end else begin
                push_request(CMD_ACQUIRE, tid_t'($urandom_range(0, 15)));
            end
        end
    endtask

    // Drive the holder up to a saturated depth, hit it a few times, then unwind.
    task automatic push_deep_nest();
        tid_t holder;
        while (!gen_lock.held)
            push_request(CMD_ACQUIRE, tid_t'($urandom_range(0, 15)));
        holder = gen_lock.owner;
        while (gen_lock.depth != DEPTH_MAX)
            push_request(CMD_ACQUIRE, holder);
        repeat (3) push_request(CMD_ACQUIRE, holder);
        while (gen_lock.held)
            push_request(CMD_RELEASE, holder);
    endtask

    task automatic flag_mismatch(input string what);
        $display("MISMATCH result %0d: %s (t=%0t)", result_idx, what, $realtime);
        mismatch_cnt++;
    endtask

    task automatic cmp_field(input string name, input int got, input int want);
        if (got != want)
            flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // Driver: on each accepted transaction predict its result, then offer the
    // next request or idle. Hold valid and data steady while the block stalls.
    always @(posedge aclk) begin
        req_t    nxt;
        result_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                r = lock_step(live_lock, cmd_t'(s_tuser), tid_t'(s_tdata[TID_W-1:0]));
                lock_result_q.push_back(r);
            end
            if (!s_tvalid || s_tready) begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    nxt      = request_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.cmd;
                    s_tdata  <= {{(IN_TDATA_W-TID_W){1'b0}}, nxt.tid};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transaction against the oldest prediction,
    // and pace m_tready, including the long back-up stall on request.
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[RESULT_W-1:0]);
                if (lock_result_q.size() == 0) begin
                    flag_mismatch("result with nothing outstanding");
                end else begin
                    want = lock_result_q.pop_front();
                    cmp_field("status", got.status, want.status);
                    cmp_field("woken_valid", got.woken_valid, want.woken_valid);
                    cmp_field("woken_thread", got.woken_thread, want.woken_thread);
                    cmp_field("holder_valid", got.holder_valid, want.holder_valid);
                    cmp_field("holder_thread", got.holder_thread, want.holder_thread);
                    cmp_field("hold_depth", got.hold_depth, want.hold_depth);
                end
                result_idx++;
            end
            if (backup_done != backup_reqs) begin
                backup_done <= backup_reqs;
                backup_left <= BACKUP_CYCLES;
                m_tready    <= 1'b0;
            end else if (backup_left != 0) begin
                backup_left <= backup_left - 1;
                m_tready    <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: give up once nothing has moved on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        live_lock = '0;
        gen_lock  = '0;

        // Directed opening: every status but count overflow, wake-up order, a queued thread
        // retrying on a free lock, releases by a stranger and on a free lock.
        push_request(CMD_RELEASE, tid_t'(3));   // free lock: not holder
        push_request(CMD_ACQUIRE, tid_t'(0));   // granted
        push_request(CMD_ACQUIRE, tid_t'(0));   // nested
        push_request(CMD_ACQUIRE, tid_t'(15));  // queued
        push_request(CMD_ACQUIRE, tid_t'(15));  // already waiting
        push_request(CMD_ACQUIRE, tid_t'(7));   // queued behind 15
        push_request(CMD_RELEASE, tid_t'(15));  // stranger release
        push_request(CMD_RELEASE, tid_t'(0));   // release nested
        push_request(CMD_RELEASE, tid_t'(0));   // released, wakes 15
        push_request(CMD_ACQUIRE, tid_t'(7));   // still queued while lock is free
        push_request(CMD_ACQUIRE, tid_t'(15));  // woken thread retries: granted
        push_request(CMD_ACQUIRE, tid_t'(0));   // queued behind 7
        push_request(CMD_RELEASE, tid_t'(15));  // released, wakes 7
        push_request(CMD_RELEASE, tid_t'(15));  // free lock again
        push_request(CMD_ACQUIRE, tid_t'(0));   // still queued, lock free
        push_request(CMD_ACQUIRE, tid_t'(5));   // granted
        push_request(CMD_RELEASE, tid_t'(5));   // released, wakes 0
        push_request(CMD_ACQUIRE, tid_t'(0));   // granted
        push_request(CMD_RELEASE, tid_t'(0));   // released, ring empty

        // First phase: light sender gaps, heavy receiver stalls; saturate the
        // depth counter half way through.
        tx_idle_pct = 8;
        rx_idle_pct = 46;
        push_traffic(PHASE_ITEMS / 2);
        push_deep_nest();
        push_traffic(PHASE_ITEMS / 2);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (request_q.size() != 0) @(posedge aclk);

        // Second phase: swap the gap rates.
        tx_idle_pct = 46;
        rx_idle_pct = 8;
        push_traffic(PHASE_ITEMS);
        while (request_q.size() != 0) @(posedge aclk);

        // Third phase: full rate both ways, with two long receiver hold-offs
        // while the sender keeps pushing.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        push_traffic(PHASE_ITEMS);
        backup_reqs = backup_reqs + 1;
        while (request_q.size() > PHASE_ITEMS / 2) @(posedge aclk);
        backup_reqs = backup_reqs + 1;

        // Drain: all requests taken, all predicted results seen, then settle.
        while (request_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (lock_result_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/rlwq_pkg.sv
src/rlwq_front.sv
src/rlwq_queue.sv
src/rlwq_back.sv
src/recursive_lock_with_wait_queue_core.sv
src/rlwq_checker.sv
bench/tb.sv
